// ----- sv/gwwb_pkg.sv -----
// gwwb_pkg: shared constants, state encoding and controller command word
// for the gray-world white balance block. No dependencies.
package gwwb_pkg;

  localparam int MaxWidthDef = 4096;
  localparam int CfgW        = 13;
  localparam int PixW        = 16;
  localparam int GainW       = 24;
  localparam int SumW        = 40;
  localparam int CntW        = 24;
  localparam int ProdW       = SumW + CntW;
  localparam int FracW       = 16;
  localparam int QuoW        = 26;
  localparam int PreShift    = QuoW - FracW;
  localparam int MulSteps    = CntW;
  localparam int DivSteps    = QuoW;
  localparam int StepW       = 5;

  localparam logic [CfgW-1:0]  FrameWidthRst = 13'd3280;
  localparam logic [GainW-1:0] GainOne       = 24'h010000;
  localparam logic [GainW-1:0] GainMax       = 24'hFFFFFF;

  // operation codes
  localparam logic OpMeasure = 1'b0;
  localparam logic OpApply   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GMUL,
    ST_GDIV0,
    ST_GDIV,
    ST_GRND,
    ST_PMUL,
    ST_POUT
  } state_e;

  typedef struct packed {
    logic measure;
    logic apply_accept;
    logic mul_load;
    logic load_blue;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic gain_write;
    logic gain_blue;
    logic pix_mul;
    logic pix_out;
  } cmd_t;

endpackage

// ----- sv/bayer_gray_world_white_balance.sv -----
// bayer_gray_world_white_balance: top level, gray-world white balance on RGGB.
// Depends on gwwb_pkg, gwwb_ctrl and gwwb_dp.
//
// Usage: a word is taken at a rising edge with start high and busy low.
// operation_i = 0 is a measure word: it updates the color sums and counts at
// the accepting edge and busy stays low, so measure words go one per cycle.
// pass_start_i on a measure word clears the statistics first.
// operation_i = 1 is an apply word: busy is high while it passes the ST_PMUL
// and ST_POUT states, and the result (corrected_pixel_o, red_gain_o,
// blue_gain_o) appears with valid_o high for exactly one cycle once registered.
// An apply word with pass_start_i first recomputes both gains: per gain a
// shift-add multiply, a setup step, a restoring divide and a rounding step,
// all while busy stays high.
// The receiver cannot stall; valid_o is a single-cycle strobe.
// Configuration: cfg_data_i is the frame width, written when cfg_valid_i and
// cfg_ready_o are both high; cfg_ready_o follows !busy.
// Reset clears position, statistics and the result strobe, sets both gains
// to 1.0 and the frame width to 3280.
module bayer_gray_world_white_balance import gwwb_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             operation_i,
  input  logic             pass_start_i,
  input  logic [PixW-1:0]  pixel_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgW-1:0]  cfg_data_i,
  output logic             valid_o,
  output logic [PixW-1:0]  corrected_pixel_o,
  output logic [GainW-1:0] red_gain_o,
  output logic [GainW-1:0] blue_gain_o
);

  cmd_t cmd;
  logic busy_int;

  gwwb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .operation_i  (operation_i),
    .pass_start_i (pass_start_i),
    .busy_o       (busy_int),
    .cmd_o        (cmd)
  );

  gwwb_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .pass_start_i      (pass_start_i),
    .pixel_i           (pixel_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .valid_o           (valid_o),
    .corrected_pixel_o (corrected_pixel_o),
    .red_gain_o        (red_gain_o),
    .blue_gain_o       (blue_gain_o)
  );

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int;

endmodule

// ----- sv/gwwb_ctrl.sv -----
// gwwb_ctrl: sequencer for measure, gain computation and pixel correction.
// Depends on gwwb_pkg.
module gwwb_ctrl import gwwb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic operation_i,
  input  logic pass_start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && (operation_i == OpApply)) begin
          if (pass_start_i) begin
            state_d = ST_GMUL;
            cnt_d   = '0;
            phase_d = 1'b0;
          end else begin
            state_d = ST_PMUL;
          end
        end
      end
      ST_GMUL: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(MulSteps - 1)) begin
          state_d = ST_GDIV0;
        end
      end
      ST_GDIV0: begin
        cnt_d   = '0;
        state_d = ST_GDIV;
      end
      ST_GDIV: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(DivSteps - 1)) begin
          state_d = ST_GRND;
        end
      end
      ST_GRND: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          cnt_d   = '0;
          state_d = ST_GMUL;
        end else begin
          state_d = ST_PMUL;
        end
      end
      ST_PMUL: begin
        state_d = ST_POUT;
      end
      ST_POUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o             = 1'b0;
        cmd_o.measure      = start_i && (operation_i == OpMeasure);
        cmd_o.apply_accept = start_i && (operation_i == OpApply);
        cmd_o.mul_load     = start_i && (operation_i == OpApply) && pass_start_i;
      end
      ST_GMUL: begin
        cmd_o.mul_step = 1'b1;
      end
      ST_GDIV0: begin
        cmd_o.div_init = 1'b1;
      end
      ST_GDIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_GRND: begin
        cmd_o.gain_write = 1'b1;
        cmd_o.gain_blue  = phase_q;
        cmd_o.mul_load   = !phase_q;
        cmd_o.load_blue  = 1'b1;
      end
      ST_PMUL: begin
        cmd_o.pix_mul = 1'b1;
      end
      ST_POUT: begin
        cmd_o.pix_out = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- sv/gwwb_dp.sv -----
// gwwb_dp: position tracking, statistics, shift-add multipliers, gain divider
// and pixel gain stage. Depends on gwwb_pkg, driven by gwwb_ctrl commands.
module gwwb_dp import gwwb_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic             pass_start_i,
  input  logic [PixW-1:0]  pixel_i,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  output logic             valid_o,
  output logic [PixW-1:0]  corrected_pixel_o,
  output logic [GainW-1:0] red_gain_o,
  output logic [GainW-1:0] blue_gain_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WidW = ColW + 1;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s,
                                              input logic [PixW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + {{(SumW + 1 - PixW){1'b0}}, v};
    return t[SumW] ? '1 : t[SumW-1:0];
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (c == '1) ? c : c + CntW'(1);
  endfunction

  // configuration and position
  logic [CfgW-1:0] frame_width_q;
  logic [WidW-1:0] width_eff;
  logic [ColW-1:0] column_q, column_d, col_cur;
  logic            odd_row_q, odd_row_d, odd_cur;
  logic [WidW-1:0] col_nxt;
  logic            red_site, blue_site, accept;

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = WidW'(1);
    end else if ({1'b0, frame_width_q} > 14'(MAX_WIDTH)) begin
      width_eff = WidW'(MAX_WIDTH);
    end else begin
      width_eff = WidW'(frame_width_q);
    end
  end

  assign accept    = cmd_i.measure || cmd_i.apply_accept;
  assign col_cur   = pass_start_i ? '0 : column_q;
  assign odd_cur   = pass_start_i ? 1'b0 : odd_row_q;
  assign red_site  = !odd_cur && !col_cur[0];
  assign blue_site = odd_cur && col_cur[0];
  assign col_nxt   = {1'b0, col_cur} + WidW'(1);

  always_comb begin
    column_d  = column_q;
    odd_row_d = odd_row_q;
    if (accept) begin
      if (col_nxt >= width_eff) begin
        column_d  = '0;
        odd_row_d = !odd_cur;
      end else begin
        column_d  = col_nxt[ColW-1:0];
        odd_row_d = odd_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FrameWidthRst;
      column_q      <= '0;
      odd_row_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_width_q <= cfg_data_i;
      end
      column_q  <= column_d;
      odd_row_q <= odd_row_d;
    end
  end

  // statistics
  logic [SumW-1:0] red_sum_q, green_sum_q, blue_sum_q;
  logic [SumW-1:0] rs_base, gs_base, bs_base;
  logic [CntW-1:0] red_cnt_q, green_cnt_q, blue_cnt_q;
  logic [CntW-1:0] rc_base, gc_base, bc_base;

  assign rs_base = pass_start_i ? '0 : red_sum_q;
  assign gs_base = pass_start_i ? '0 : green_sum_q;
  assign bs_base = pass_start_i ? '0 : blue_sum_q;
  assign rc_base = pass_start_i ? '0 : red_cnt_q;
  assign gc_base = pass_start_i ? '0 : green_cnt_q;
  assign bc_base = pass_start_i ? '0 : blue_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
      red_cnt_q   <= '0;
      green_cnt_q <= '0;
      blue_cnt_q  <= '0;
    end else if (cmd_i.measure) begin
      red_sum_q   <= red_site ? sat_add(rs_base, pixel_i) : rs_base;
      red_cnt_q   <= red_site ? sat_inc(rc_base) : rc_base;
      blue_sum_q  <= blue_site ? sat_add(bs_base, pixel_i) : bs_base;
      blue_cnt_q  <= blue_site ? sat_inc(bc_base) : bc_base;
      green_sum_q <= (!red_site && !blue_site) ? sat_add(gs_base, pixel_i) : gs_base;
      green_cnt_q <= (!red_site && !blue_site) ? sat_inc(gc_base) : gc_base;
    end
  end

  // shift-add multipliers: numerator green_sum*count, divisor green_count*sum
  logic [ProdW-1:0] num_mc_q, den_mc_q, num_acc_q, den_acc_q;
  logic [CntW-1:0]  num_mp_q, den_mp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      num_mc_q  <= ProdW'(green_sum_q);
      num_mp_q  <= cmd_i.load_blue ? blue_cnt_q : red_cnt_q;
      den_mc_q  <= ProdW'(cmd_i.load_blue ? blue_sum_q : red_sum_q);
      den_mp_q  <= green_cnt_q;
      num_acc_q <= '0;
      den_acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (num_mp_q[0]) begin
        num_acc_q <= num_acc_q + num_mc_q;
      end
      if (den_mp_q[0]) begin
        den_acc_q <= den_acc_q + den_mc_q;
      end
      num_mc_q <= {num_mc_q[ProdW-2:0], 1'b0};
      den_mc_q <= {den_mc_q[ProdW-2:0], 1'b0};
      num_mp_q <= {1'b0, num_mp_q[CntW-1:1]};
      den_mp_q <= {1'b0, den_mp_q[CntW-1:1]};
    end
  end

  // restoring divider over the low quotient bits
  logic [ProdW-1:0] rem_q;
  logic [QuoW-1:0]  nbits_q, quo_q;
  logic             sat_q;
  logic [ProdW:0]   trial, trial_sub;
  logic [ProdW:0]   twice_rem;
  logic             round_up;
  logic [QuoW:0]    quo_rnd;
  logic [GainW-1:0] gain_new;

  assign trial     = {rem_q, nbits_q[QuoW-1]};
  assign trial_sub = trial - {1'b0, den_acc_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      sat_q   <= (num_acc_q >> PreShift) >= den_acc_q;
      rem_q   <= num_acc_q >> PreShift;
      nbits_q <= {num_acc_q[PreShift-1:0], {FracW{1'b0}}};
      quo_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial_sub[ProdW]) begin
        rem_q <= trial_sub[ProdW-1:0];
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= trial[ProdW-1:0];
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
      nbits_q <= {nbits_q[QuoW-2:0], 1'b0};
    end
  end

  assign twice_rem = {rem_q, 1'b0};
  assign round_up  = (twice_rem > {1'b0, den_acc_q}) ||
                     ((twice_rem == {1'b0, den_acc_q}) && quo_q[0]);
  assign quo_rnd   = {1'b0, quo_q} + (QuoW + 1)'(round_up);
  assign gain_new  = (sat_q || (quo_rnd > (QuoW + 1)'(GainMax))) ? GainMax
                                                                 : quo_rnd[GainW-1:0];

  logic [GainW-1:0] red_gain_q, blue_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_gain_q  <= GainOne;
      blue_gain_q <= GainOne;
    end else if (cmd_i.gain_write) begin
      if (cmd_i.gain_blue) begin
        blue_gain_q <= gain_new;
      end else begin
        red_gain_q <= gain_new;
      end
    end
  end

  // pixel gain stage
  logic [PixW-1:0]         pix_q;
  logic                    red_q, blue_q, green_q;
  logic [PixW+GainW-1:0]   pprod_q;
  logic [GainW-1:0]        pgain;
  logic [GainW-1:0]        pq;
  logic [FracW-1:0]        pfrac;
  logic                    pup;
  logic [GainW:0]          pq_rnd;
  logic [PixW-1:0]         pix_new;

  assign pgain = red_q ? red_gain_q : blue_gain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_accept) begin
      pix_q  <= pixel_i;
      red_q  <= red_site;
      blue_q <= blue_site;
    end
    if (cmd_i.pix_mul) begin
      pprod_q <= (PixW + GainW)'(pix_q) * (PixW + GainW)'(pgain);
      green_q <= !red_q && !blue_q;
    end
  end

  assign pq      = pprod_q[PixW+GainW-1:FracW];
  assign pfrac   = pprod_q[FracW-1:0];
  assign pup     = (pfrac > {1'b1, {(FracW-1){1'b0}}}) ||
                   ((pfrac == {1'b1, {(FracW-1){1'b0}}}) && pq[0]);
  assign pq_rnd  = {1'b0, pq} + (GainW + 1)'(pup);
  assign pix_new = green_q ? pix_q
                 : (pq_rnd > (GainW + 1)'({PixW{1'b1}})) ? {PixW{1'b1}}
                 : pq_rnd[PixW-1:0];

  logic             valid_q;
  logic [PixW-1:0]  out_pix_q;
  logic [GainW-1:0] out_rg_q, out_bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.pix_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_out) begin
      out_pix_q <= pix_new;
      out_rg_q  <= red_gain_q;
      out_bg_q  <= blue_gain_q;
    end
  end

  assign valid_o           = valid_q;
  assign corrected_pixel_o = out_pix_q;
  assign red_gain_o        = out_rg_q;
  assign blue_gain_o       = out_bg_q;

endmodule

// ----- verif/tb_bayer_gray_world_white_balance.sv -----
// tb_bayer_gray_world_white_balance: self-checking bench for the RGGB gray-world
// white balance block. Depends on gwwb_pkg and bayer_gray_world_white_balance;
// a built-in predictor tracks position, statistics and gains to check each result.
module tb_bayer_gray_world_white_balance;
  import gwwb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CycleLimit = 1000000;
  localparam int   PrintLimit = 40;
  localparam logic [FracW-1:0] HalfLsb = 16'h8000;

  typedef enum int unsigned {
    STYLE_UNIFORM,
    STYLE_DARK_COLOR,
    STYLE_TINY,
    STYLE_BRIGHT_COLOR,
    STYLE_EXTREME
  } pix_style_e;

  typedef struct packed {
    logic [PixW-1:0]  pixel;
    logic [GainW-1:0] red_gain;
    logic [GainW-1:0] blue_gain;
  } wb_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             operation_i;
  logic             pass_start_i;
  logic [PixW-1:0]  pixel_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i;
  logic             valid_o;
  logic [PixW-1:0]  corrected_pixel_o;
  logic [GainW-1:0] red_gain_o;
  logic [GainW-1:0] blue_gain_o;

  wb_result_t       expected_results[$];
  int unsigned      fail_count;
  int unsigned      cycle_count;
  int unsigned      words_sent;
  int unsigned      idle_pct;

  // predictor state
  logic [CfgW-1:0]  frame_width_m;
  int unsigned      col_pos;
  logic             row_odd;
  logic [SumW-1:0]  red_sum_m, green_sum_m, blue_sum_m;
  logic [CntW-1:0]  red_cnt_m, green_cnt_m, blue_cnt_m;
  logic [GainW-1:0] red_gain_m, blue_gain_m;

  bayer_gray_world_white_balance uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .pass_start_i      (pass_start_i),
    .pixel_i           (pixel_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .valid_o           (valid_o),
    .corrected_pixel_o (corrected_pixel_o),
    .red_gain_o        (red_gain_o),
    .blue_gain_o       (blue_gain_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_width(logic [CfgW-1:0] w);
    if (w == '0) return 1;
    if (w > CfgW'(MaxWidthDef)) return MaxWidthDef;
    return 32'(w);
  endfunction

  function automatic logic [SumW-1:0] sum_add(logic [SumW-1:0] s, logic [PixW-1:0] p);
    logic [SumW:0] t;
    t = {1'b0, s} + (SumW + 1)'(p);
    return t[SumW] ? {SumW{1'b1}} : t[SumW-1:0];
  endfunction

  function automatic logic [CntW-1:0] count_inc(logic [CntW-1:0] c);
    return (&c) ? c : c + CntW'(1);
  endfunction

  // green_sum * count / (green_count * color_sum) in Q8.16, round half even
  function automatic logic [GainW-1:0] gray_gain(logic [SumW-1:0] csum,
                                                 logic [CntW-1:0] cnt);
    logic [127:0] num, den, quo, rem;
    den = 128'(green_cnt_m);
    den = den * 128'(csum);
    if (den == '0) return GainMax;
    num = 128'(green_sum_m);
    num = num * 128'(cnt);
    num = num << FracW;
    quo = num / den;
    rem = num % den;
    if (quo > 128'(GainMax)) return GainMax;
    if ((rem << 1) > den || ((rem << 1) == den && quo[0])) quo = quo + 128'(1);
    return (quo > 128'(GainMax)) ? GainMax : quo[GainW-1:0];
  endfunction

  function automatic logic [PixW-1:0] scale_pixel(logic [PixW-1:0] p, logic [GainW-1:0] g);
    logic [PixW+GainW-1:0] prod, q;
    prod = (PixW + GainW)'(p) * (PixW + GainW)'(g);
    q = prod >> FracW;
    if (prod[FracW-1:0] > HalfLsb || (prod[FracW-1:0] == HalfLsb && q[0]))
      q = q + (PixW + GainW)'(1);
    return (q > (PixW + GainW)'({PixW{1'b1}})) ? {PixW{1'b1}} : q[PixW-1:0];
  endfunction

  task automatic predict_white_balance(input logic op, input logic first,
                                       input logic [PixW-1:0] pix);
    int unsigned eff;
    logic red_site, blue_site;
    wb_result_t res;
    eff = eff_width(frame_width_m);
    if (first) begin
      col_pos = 0;
      row_odd = 1'b0;
    end
    red_site  = !row_odd && (col_pos % 2 == 0);
    blue_site = row_odd && (col_pos % 2 == 1);
    if (op == OpMeasure) begin
      if (first) begin
        red_sum_m = '0; green_sum_m = '0; blue_sum_m = '0;
        red_cnt_m = '0; green_cnt_m = '0; blue_cnt_m = '0;
      end
      if (red_site) begin
        red_sum_m = sum_add(red_sum_m, pix);
        red_cnt_m = count_inc(red_cnt_m);
      end else if (blue_site) begin
        blue_sum_m = sum_add(blue_sum_m, pix);
        blue_cnt_m = count_inc(blue_cnt_m);
      end else begin
        green_sum_m = sum_add(green_sum_m, pix);
        green_cnt_m = count_inc(green_cnt_m);
      end
    end else begin
      if (first) begin
        red_gain_m  = gray_gain(red_sum_m, red_cnt_m);
        blue_gain_m = gray_gain(blue_sum_m, blue_cnt_m);
      end
      res.pixel = red_site ? scale_pixel(pix, red_gain_m) :
                  blue_site ? scale_pixel(pix, blue_gain_m) : pix;
      res.red_gain  = red_gain_m;
      res.blue_gain = blue_gain_m;
      expected_results.push_back(res);
    end
    col_pos++;
    if (col_pos >= eff) begin
      col_pos = 0;
      row_odd = !row_odd;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= PrintLimit)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    wb_result_t want;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, pixel", 32'(corrected_pixel_o), '0);
      end else begin
        want = expected_results.pop_front();
        if (corrected_pixel_o !== want.pixel)
          report_mismatch("corrected_pixel", 32'(corrected_pixel_o), 32'(want.pixel));
        if (red_gain_o !== want.red_gain)
          report_mismatch("red_gain", 32'(red_gain_o), 32'(want.red_gain));
        if (blue_gain_o !== want.blue_gain)
          report_mismatch("blue_gain", 32'(blue_gain_o), 32'(want.blue_gain));
      end
    end
  end

  // start stays high after a word is taken; the caller drives it in the same step
  task automatic send_word(input logic op, input logic first, input logic [PixW-1:0] pix);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    pass_start_i <= first;
    pixel_i      <= pix;
    do @(posedge clk_i); while (busy);
    predict_white_balance(op, first, pix);
    words_sent++;
  endtask

  task automatic wait_drained(input int unsigned settle);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_frame_width(input logic [CfgW-1:0] w);
    wait_drained(8);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frame_width_m = w;
  endtask

  function automatic logic [PixW-1:0] pick_pixel(pix_style_e style, logic color);
    case (style)
      STYLE_UNIFORM:      return PixW'($urandom);
      STYLE_DARK_COLOR:   return color ? PixW'($urandom_range(255))
                                       : PixW'($urandom_range(32768, 65535));
      STYLE_TINY:         return PixW'($urandom_range(3));
      STYLE_BRIGHT_COLOR: return color ? PixW'($urandom_range(32768, 65535))
                                       : PixW'($urandom_range(255));
      default:            return ($urandom_range(1) != 0) ? {PixW{1'b1}} : {PixW{1'b0}};
    endcase
  endfunction

  function automatic logic color_site(int unsigned idx, int unsigned eff);
    int unsigned col, row;
    col = idx % eff;
    row = (idx / eff) % 2;
    return (row == 0 && col % 2 == 0) || (row == 1 && col % 2 == 1);
  endfunction

  task automatic run_random_frame();
    int unsigned choice, eff, len;
    logic [CfgW-1:0] w;
    logic apply_first;
    pix_style_e style;
    choice = $urandom_range(99);
    if (choice < 80) begin
      if (choice < 5) w = '0;
      else if (choice < 10)
        w = ($urandom_range(1) != 0) ? {CfgW{1'b1}} : CfgW'($urandom_range(4097, 8191));
      else if (choice < 14) w = CfgW'(MaxWidthDef);
      else if (choice < 20) w = CfgW'(1);
      else w = CfgW'($urandom_range(2, 12));
      write_frame_width(w);
    end
    eff = eff_width(frame_width_m);
    len = eff * $urandom_range(1, 6);
    if (len > 60) len = $urandom_range(1, 60);
    if ($urandom_range(9) == 0) len = $urandom_range(1, len);
    style = pix_style_e'($urandom_range(4));
    for (int unsigned i = 0; i < len; i++)
      send_word(OpMeasure, i == 0, pick_pixel(style, color_site(i, eff)));
    apply_first = ($urandom_range(9) != 0);
    for (int unsigned i = 0; i < len; i++)
      send_word(OpApply, apply_first && i == 0, pick_pixel(style, color_site(i, eff)));
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6))
        send_word(1'($urandom_range(1)), $urandom_range(4) == 0, PixW'($urandom));
    end
  endtask

  task automatic test_reset_gains();
    idle_pct = 0;
    send_word(OpApply, 1'b0, 16'hFFFF);
    // empty statistics give full-scale gains
    send_word(OpApply, 1'b1, 16'hFFFF);
    send_word(OpApply, 1'b0, 16'h0000);
  endtask

  task automatic test_pixel_rounding();
    idle_pct = 0;
    write_frame_width(2);
    // red gain 1.5, blue gain 1.0
    send_word(OpMeasure, 1'b1, 16'd2);
    send_word(OpMeasure, 1'b0, 16'd3);
    send_word(OpMeasure, 1'b0, 16'd3);
    send_word(OpMeasure, 1'b0, 16'd3);
    send_word(OpApply, 1'b1, 16'd1);
    send_word(OpApply, 1'b0, 16'hFFFF);
    send_word(OpApply, 1'b0, 16'h0000);
    send_word(OpApply, 1'b0, 16'h8001);
    send_word(OpApply, 1'b0, 16'd3);
  endtask

  task automatic test_gain_tie();
    idle_pct = 0;
    // red quotient lands exactly halfway between two codes
    send_word(OpMeasure, 1'b1, 16'hFFFF);
    send_word(OpMeasure, 1'b0, 16'd0);
    send_word(OpMeasure, 1'b0, 16'd1);
    send_word(OpMeasure, 1'b0, 16'd1);
    send_word(OpMeasure, 1'b0, 16'd1);
    send_word(OpMeasure, 1'b0, 16'd1);
    send_word(OpMeasure, 1'b0, 16'd1);
    send_word(OpMeasure, 1'b0, 16'd0);
    send_word(OpApply, 1'b1, 16'hFFFF);
  endtask

  task automatic test_width_change();
    idle_pct = 0;
    write_frame_width(4);
    send_word(OpMeasure, 1'b1, 16'd10);
    send_word(OpMeasure, 1'b0, 16'd20);
    send_word(OpMeasure, 1'b0, 16'd30);
    // column already past the new width, row wraps after the next word
    write_frame_width(2);
    send_word(OpMeasure, 1'b0, 16'd40);
    send_word(OpApply, 1'b1, 16'd50);
  endtask

  task automatic test_random_frames(input int unsigned pct, input int unsigned count);
    int unsigned stop_at;
    idle_pct = pct;
    stop_at = words_sent + count;
    while (words_sent < stop_at) run_random_frame();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    operation_i  <= OpMeasure;
    pass_start_i <= 1'b0;
    pixel_i      <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    fail_count    = 0;
    cycle_count   = 0;
    words_sent    = 0;
    idle_pct      = 0;
    frame_width_m = FrameWidthRst;
    col_pos       = 0;
    row_odd       = 1'b0;
    red_sum_m = '0; green_sum_m = '0; blue_sum_m = '0;
    red_cnt_m = '0; green_cnt_m = '0; blue_cnt_m = '0;
    red_gain_m    = GainOne;
    blue_gain_m   = GainOne;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_gains();
    test_pixel_rounding();
    test_gain_tie();
    test_width_change();
    test_random_frames(0, 400);
    test_random_frames(85, 400);
    test_random_frames(31, 400);
    test_random_frames(0, 400);

    wait_drained(16);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
